// File: rtl/core/life_grid_generation_step_unit_defines.svh
// Assertion macros for the life grid generation step unit.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef LIFE_GRID_GENERATION_STEP_UNIT_DEFINES_SVH
`define LIFE_GRID_GENERATION_STEP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LGS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define LGS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lgs_pkg.sv
// Shared types and constants for the life grid generation step unit.
// No dependencies.
package lgs_pkg;

    // Default grid size
    localparam int DEF_GRID_ROWS = 8;
    localparam int DEF_GRID_COLS = 8;

    // Fixed payload field widths
    localparam int REQ_TYPE_W  = 1;
    localparam int ROW_IDX_W   = 3;
    localparam int ROW_CELLS_W = 8;

    // Request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_LOAD = 1'b0;
    localparam logic [REQ_TYPE_W-1:0] REQ_STEP = 1'b1;

    // B3/S23 rule constants on a 4-bit neighbour count
    localparam int NBR_CNT_W = 4;
    localparam logic [NBR_CNT_W-1:0] SURVIVE_LOW  = 4'd2;
    localparam logic [NBR_CNT_W-1:0] SURVIVE_HIGH = 4'd3;
    localparam logic [NBR_CNT_W-1:0] BIRTH_COUNT  = 4'd3;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_EMIT
    } lgs_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // write one row from the request beat
        logic step;     // replace grid with next generation
        logic prime;    // load output register with row 0
        logic advance;  // move output register to next row
    } lgs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last;     // output register holds the final row
    } lgs_stat_t;

endpackage

// File: rtl/core/lgs_chan_if.sv
// Valid/ready channel interfaces for request and row beats.
// Depends on lgs_pkg for field widths.
interface lgs_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [lgs_pkg::REQ_TYPE_W-1:0]       req_type;
    logic [lgs_pkg::ROW_IDX_W-1:0]        row_index;
    logic [lgs_pkg::ROW_CELLS_W-1:0]      row_cells;

    modport source (output valid, output req_type, output row_index, output row_cells,
                    input ready);
    modport sink   (input valid, input req_type, input row_index, input row_cells,
                    output ready);
endinterface

interface lgs_row_if;
    logic                                 valid;
    logic                                 ready;
    logic [lgs_pkg::ROW_IDX_W-1:0]        out_row_index;
    logic [lgs_pkg::ROW_CELLS_W-1:0]      out_row_cells;
    logic                                 last_row;

    modport source (output valid, output out_row_index, output out_row_cells,
                    output last_row, input ready);
    modport sink   (input valid, input out_row_index, input out_row_cells,
                    input last_row, output ready);
endinterface

// File: rtl/core/life_grid_generation_step_unit.sv
// Conway life (B3/S23) grid of GRID_ROWS x GRID_COLS cells, edges not wrapped.
//
// Channels: req (sink) carries req_type, row_index, row_cells; rsp (source)
// carries out_row_index, out_row_cells, last_row. A beat moves on a rising
// edge with valid and ready both high.
// A load beat (req_type 0) writes one row on the accepting edge; a row index at
// or beyond GRID_ROWS is dropped, and columns at GRID_COLS or above are cut.
// A step beat (req_type 1) updates every cell at once on the accepting edge,
// fills the output register in the prime state, then offers rows 0 to
// GRID_ROWS-1, one per cycle while rsp.ready is high, with last_row set on the final one.
// One request is handled at a time: req.ready is low from a step beat until
// the last row beat has gone. A stall on rsp holds the current row stable.
// Reset (rst_n low, asynchronous) clears the grid to all dead and returns
// the block to idle with req.ready high.
// Depends on lgs_pkg, lgs_chan_if, lgs_ctrl and lgs_datapath.
module life_grid_generation_step_unit #(
    parameter int GRID_ROWS = lgs_pkg::DEF_GRID_ROWS,
    parameter int GRID_COLS = lgs_pkg::DEF_GRID_COLS
) (
    input  logic         clk,
    input  logic         rst_n,
    lgs_req_if.sink      req,
    lgs_row_if.source    rsp
);

    lgs_pkg::lgs_cmd_t  cmd;
    lgs_pkg::lgs_stat_t stat;

    // Sequencer
    lgs_ctrl u_lgs_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_req_type (req.req_type),
        .in_ready    (req.ready),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .cmd         (cmd),
        .stat        (stat)
    );

    // Grid and row output
    lgs_datapath #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_lgs_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .row_index     (req.row_index),
        .row_cells     (req.row_cells),
        .out_row_index (rsp.out_row_index),
        .out_row_cells (rsp.out_row_cells),
        .last_row      (rsp.last_row)
    );

endmodule

// File: rtl/core/lgs_ctrl.sv
// Sequencing controller: accepts requests, runs a step, streams rows out.
// Depends on lgs_pkg.
module lgs_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [lgs_pkg::REQ_TYPE_W-1:0]  in_req_type,
    output logic                            in_ready,
    output logic                            out_valid,
    input  logic                            out_ready,
    output lgs_pkg::lgs_cmd_t               cmd,
    input  lgs_pkg::lgs_stat_t              stat
);

    lgs_pkg::lgs_state_t state_reg;
    lgs_pkg::lgs_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lgs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            lgs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_req_type == lgs_pkg::REQ_STEP)
                    begin
                        cmd.step   = 1'b1;
                        state_next = lgs_pkg::ST_PRIME;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            lgs_pkg::ST_PRIME:
            begin
                cmd.prime  = 1'b1;
                state_next = lgs_pkg::ST_EMIT;
            end
            lgs_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (stat.last)
                    begin
                        state_next = lgs_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = lgs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/lgs_datapath.sv
// Grid store, next-generation logic, row counter and output register.
// Depends on lgs_pkg.
module lgs_datapath #(
    parameter int GRID_ROWS = lgs_pkg::DEF_GRID_ROWS,
    parameter int GRID_COLS = lgs_pkg::DEF_GRID_COLS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lgs_pkg::lgs_cmd_t                cmd,
    output lgs_pkg::lgs_stat_t               stat,
    input  logic [lgs_pkg::ROW_IDX_W-1:0]    row_index,
    input  logic [lgs_pkg::ROW_CELLS_W-1:0]  row_cells,
    output logic [lgs_pkg::ROW_IDX_W-1:0]    out_row_index,
    output logic [lgs_pkg::ROW_CELLS_W-1:0]  out_row_cells,
    output logic                             last_row
);

    localparam int ROW_AW = $clog2(GRID_ROWS);
    localparam int CELL_W = (GRID_COLS > lgs_pkg::ROW_CELLS_W) ? GRID_COLS
                                                                : lgs_pkg::ROW_CELLS_W;
    localparam int IDX_W  = (ROW_AW > lgs_pkg::ROW_IDX_W) ? ROW_AW : lgs_pkg::ROW_IDX_W;
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(GRID_ROWS - 1);

    logic [GRID_COLS-1:0]              grid_reg [GRID_ROWS];
    logic [GRID_COLS-1:0]              gen_next [GRID_ROWS];
    logic [GRID_COLS+1:0]              pad      [GRID_ROWS+2];
    logic [ROW_AW-1:0]                 cnt_reg;
    logic [ROW_AW-1:0]                 cnt_inc;
    logic [lgs_pkg::ROW_CELLS_W-1:0]   out_cells_reg;
    logic [CELL_W-1:0]                 load_wide;
    logic [GRID_COLS-1:0]              load_row;
    logic [CELL_W-1:0]                 rd_wide;
    logic [GRID_COLS-1:0]              rd_row;
    logic [IDX_W-1:0]                  idx_wide;

    // Grid with a border of dead cells
    always_comb
    begin
        pad[0]             = '0;
        pad[GRID_ROWS + 1] = '0;
        for (int r = 0; r < GRID_ROWS; r++)
        begin
            pad[r + 1] = {1'b0, grid_reg[r], 1'b0};
        end
    end

    // Next generation, every cell in parallel
    always_comb
    begin
        logic [lgs_pkg::NBR_CNT_W-1:0] nbr;
        logic                          alive;
        nbr   = '0;
        alive = 1'b0;
        for (int r = 0; r < GRID_ROWS; r++)
        begin
            for (int c = 0; c < GRID_COLS; c++)
            begin
                nbr = '0;
                for (int dr = 0; dr < 3; dr++)
                begin
                    for (int dc = 0; dc < 3; dc++)
                    begin
                        if (dr != 1 || dc != 1)
                        begin
                            nbr = nbr + lgs_pkg::NBR_CNT_W'(pad[r + dr][c + dc]);
                        end
                    end
                end
                alive = grid_reg[r][c];
                gen_next[r][c] = alive ? (nbr == lgs_pkg::SURVIVE_LOW ||
                                          nbr == lgs_pkg::SURVIVE_HIGH)
                                       : (nbr == lgs_pkg::BIRTH_COUNT);
            end
        end
    end

    // Fit loaded bits to the grid width; extra columns dropped
    assign load_wide = CELL_W'(row_cells);
    assign load_row  = load_wide[GRID_COLS-1:0];

    // Grid store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < GRID_ROWS; r++)
            begin
                grid_reg[r] <= '0;
            end
        end
        else if (cmd.step)
        begin
            grid_reg <= gen_next;
        end
        else if (cmd.load)
        begin
            // rows beyond the grid are ignored
            for (int r = 0; r < GRID_ROWS; r++)
            begin
                if (int'(row_index) == r)
                begin
                    grid_reg[r] <= load_row;
                end
            end
        end
    end

    // Row to place in the output register
    assign cnt_inc = cnt_reg + 1'b1;
    assign rd_row  = cmd.prime ? grid_reg[0] : grid_reg[cnt_inc];
    assign rd_wide = CELL_W'(rd_row);

    // Output row counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.prime)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.advance)
        begin
            cnt_reg <= cnt_inc;
        end
    end

    // Output cell register
    always_ff @(posedge clk)
    begin
        if (cmd.prime || cmd.advance)
        begin
            out_cells_reg <= rd_wide[lgs_pkg::ROW_CELLS_W-1:0];
        end
    end

    assign idx_wide      = IDX_W'(cnt_reg);
    assign out_row_index = idx_wide[lgs_pkg::ROW_IDX_W-1:0];
    assign out_row_cells = out_cells_reg;
    assign last_row      = (cnt_reg == LAST_ROW);
    assign stat.last     = last_row;

endmodule

// File: rtl/core/lgs_chk.sv
// Port-level checks for the life grid generation step unit, bound to the top.
// Depends on lgs_pkg and life_grid_generation_step_unit_defines.svh.
`include "life_grid_generation_step_unit_defines.svh"

module lgs_chk (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic [lgs_pkg::REQ_TYPE_W-1:0]   req_type,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic [lgs_pkg::ROW_IDX_W-1:0]    rsp_row_index,
    input logic [lgs_pkg::ROW_CELLS_W-1:0]  rsp_row_cells,
    input logic                             rsp_last
);

    // Never taking requests while rows are on offer
    `LGS_ASSERT_NOW(a_one_side, 1'b1, !(req_ready && rsp_valid), "req ready while rows pending")

    // A step beat closes the request side and rows are not yet offered
    `LGS_ASSERT_NEXT(a_step_busy, req_valid && req_ready && req_type == lgs_pkg::REQ_STEP, !req_ready && !rsp_valid, "step not followed by prime cycle")

    // Rows come out in order
    `LGS_ASSERT_NEXT(a_row_seq, rsp_valid && rsp_ready && !rsp_last, rsp_valid && rsp_row_index == $past(rsp_row_index) + 3'd1, "row index out of sequence")

    // After the last row the block is idle again
    `LGS_ASSERT_NEXT(a_last_idle, rsp_valid && rsp_ready && rsp_last, !rsp_valid && req_ready, "not idle after last row")

    // A stalled row beat holds
    `LGS_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_row_cells) && $stable(rsp_row_index), "stalled row beat changed")

endmodule

bind life_grid_generation_step_unit lgs_chk u_lgs_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_type      (req.req_type),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_row_index (rsp.out_row_index),
    .rsp_row_cells (rsp.out_row_cells),
    .rsp_last      (rsp.last_row)
);
